### hw/rtl/bsed_pkg.sv
// Shared types and constants of the backslash escape decoder.
// Holds the internal byte token, the replacement rules and a token helper.
// No dependencies; the front, queue, stages and top level use it.
package bsed_pkg;

  // Byte value of the backslash character.
  localparam logic [7:0] BSL = 8'h5C;

  // Number of replacement stages in the back part.
  localparam int unsigned NUM_STAGES = 5;

  // One byte travelling between the front, the queue and the stages.
  // A bare token has no byte and only carries the end of a message.
  // A bypass token passes every stage untouched and clears its held backslash.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       bypass;
  } token_t;

  // One replacement rule: the byte after a backslash and what replaces the pair.
  typedef struct packed {
    logic [7:0] target;
    logic [7:0] repl;
  } rule_t;

  // Rules in stage order: newline, carriage return, tab, NUL, backslash.
  localparam rule_t RULES [NUM_STAGES] = '{
    '{target: 8'h6E, repl: 8'h0A},
    '{target: 8'h72, repl: 8'h0D},
    '{target: 8'h74, repl: 8'h09},
    '{target: 8'h30, repl: 8'h00},
    '{target: BSL,   repl: BSL}
  };

  // Builds an ordinary data token that is not the end of a message.
  function automatic token_t byte_tok(input logic [7:0] b);
    token_t t;
    t.data     = b;
    t.has_byte = 1'b1;
    t.last     = 1'b0;
    t.bypass   = 1'b0;
    return t;
  endfunction

endpackage

### hw/rtl/bsed_in_if.sv
// Input channel of the backslash escape decoder: one raw byte per item.
// Carries valid, ready and the payload; no dependencies.
interface bsed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

### hw/rtl/bsed_out_if.sv
// Output channel of the backslash escape decoder: at most one decoded byte
// per item. Carries valid, ready and the payload; no dependencies.
interface bsed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output out_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input end_of_message,
                  output ready);
endinterface

### hw/rtl/bsed_hex_front.sv
// Front part of the decoder: accepts input items, decodes hex escapes and
// issues zero to three tokens per item, one per cycle while the queue
// takes them. Depends on bsed_pkg and bsed_in_if.
module bsed_hex_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enable_i,
  bsed_in_if.sink         in_i,
  output logic            tok_valid_o,
  output bsed_pkg::token_t tok_o,
  input  logic            tok_ready_i
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BSL   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Letters of either case map through their low nibble plus nine.
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  phase_e           phase_q, phase_d;
  logic [7:0]       held_q, held_d;
  bsed_pkg::token_t slot_q [3];
  logic [1:0]       cnt_q;
  bsed_pkg::token_t gen [3];
  logic [1:0]       gen_n;
  logic             push, pop;

  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = slot_q[0];
  assign pop         = tok_valid_o && tok_ready_i;
  // A new item is taken once the last token of the previous one leaves.
  assign in_i.ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && tok_ready_i);
  assign push        = in_i.valid && in_i.ready;

  // Tokens that the current input item produces, and the next escape state.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gen[i] = '0;
    end
    gen_n   = 2'd0;
    phase_d = phase_q;
    held_d  = held_q;
    if (!enable_i) begin
      gen[0]        = bsed_pkg::byte_tok(in_i.in_byte);
      gen[0].bypass = 1'b1;
      gen[0].last   = in_i.is_last;
      gen_n         = 2'd1;
      phase_d       = PH_IDLE;
      held_d        = 8'h00;
    end else begin
      unique case (phase_q)
        PH_BSL: begin
          if (is_hex(in_i.in_byte)) begin
            held_d  = in_i.in_byte;
            phase_d = PH_DIGIT;
          end else begin
            gen[0]  = bsed_pkg::byte_tok(bsed_pkg::BSL);
            gen[1]  = bsed_pkg::byte_tok(in_i.in_byte);
            gen_n   = 2'd2;
            phase_d = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (is_hex(in_i.in_byte)) begin
            gen[0] = bsed_pkg::byte_tok({hex_nib(held_q), hex_nib(in_i.in_byte)});
            gen_n  = 2'd1;
          end else begin
            gen[0] = bsed_pkg::byte_tok(bsed_pkg::BSL);
            gen[1] = bsed_pkg::byte_tok(held_q);
            gen[2] = bsed_pkg::byte_tok(in_i.in_byte);
            gen_n  = 2'd3;
          end
          phase_d = PH_IDLE;
          held_d  = 8'h00;
        end
        default: begin
          phase_d = PH_IDLE;
          if (in_i.in_byte == bsed_pkg::BSL) begin
            phase_d = PH_BSL;
          end else begin
            gen[0] = bsed_pkg::byte_tok(in_i.in_byte);
            gen_n  = 2'd1;
          end
        end
      endcase
      // The end of a message drops an unfinished escape and marks the final token.
      if (in_i.is_last) begin
        phase_d = PH_IDLE;
        held_d  = 8'h00;
        if (gen_n == 2'd0) begin
          gen[0].last = 1'b1;
          gen_n       = 2'd1;
        end else begin
          gen[gen_n - 2'd1].last = 1'b1;
        end
      end
    end
  end

  // Escape state and the small token buffer, head in slot zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
      cnt_q   <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        slot_q[i] <= '0;
      end
    end else if (push) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      cnt_q   <= gen_n;
      for (int i = 0; i < 3; i++) begin
        slot_q[i] <= gen[i];
      end
    end else if (pop) begin
      cnt_q     <= cnt_q - 2'd1;
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule

### hw/rtl/bsed_fifo.sv
// Short register queue of tokens between the front and the back part.
// Lets each side stall on its own. Depends on bsed_pkg.
module bsed_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  bsed_pkg::token_t push_tok_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output bsed_pkg::token_t pop_tok_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsed_pkg::token_t mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_tok_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage is written at the write pointer only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_tok_i;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/bsed_repl_stage.sv
// One replacement stage of the back part: turns a backslash and the rule's
// target byte into the replacement byte, with an output and a spill register.
// Depends on bsed_pkg.
module bsed_repl_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsed_pkg::rule_t  rule_i,
  input  logic             in_valid_i,
  input  bsed_pkg::token_t in_tok_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output bsed_pkg::token_t out_tok_o,
  input  logic             out_ready_i
);

  logic             pend_q, pend_d;
  logic             out_valid_q, ext_valid_q;
  bsed_pkg::token_t out_tok_q, ext_tok_q;
  bsed_pkg::token_t o1, o2;
  logic [1:0]       n;
  logic             slot_free, in_fire;
  logic             is_bsl;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = slot_free && !ext_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;
  assign is_bsl      = (in_tok_i.data == bsed_pkg::BSL);

  // Up to two tokens leave for each token that enters.
  always_comb begin
    o1     = '0;
    o2     = '0;
    n      = 2'd0;
    pend_d = pend_q;
    if (in_tok_i.bypass) begin
      o1     = in_tok_i;
      n      = 2'd1;
      pend_d = 1'b0;
    end else if (!in_tok_i.has_byte) begin
      // Bare end marker: release a held backslash or pass the marker on.
      o1      = in_tok_i;
      if (pend_q) begin
        o1 = bsed_pkg::byte_tok(bsed_pkg::BSL);
      end
      o1.last = 1'b1;
      n       = 2'd1;
      pend_d  = 1'b0;
    end else if (pend_q) begin
      if (in_tok_i.data == rule_i.target) begin
        o1      = bsed_pkg::byte_tok(rule_i.repl);
        o1.last = in_tok_i.last;
        n       = 2'd1;
        pend_d  = 1'b0;
      end else if (is_bsl) begin
        // The older backslash goes out, the new one is held unless the message ends.
        o1 = bsed_pkg::byte_tok(bsed_pkg::BSL);
        n  = 2'd1;
        if (in_tok_i.last) begin
          o2      = bsed_pkg::byte_tok(bsed_pkg::BSL);
          o2.last = 1'b1;
          n       = 2'd2;
          pend_d  = 1'b0;
        end
      end else begin
        o1      = bsed_pkg::byte_tok(bsed_pkg::BSL);
        o2      = in_tok_i;
        n       = 2'd2;
        pend_d  = 1'b0;
      end
    end else if (is_bsl) begin
      if (in_tok_i.last) begin
        o1 = in_tok_i;
        n  = 2'd1;
      end else begin
        pend_d = 1'b1;
      end
    end else begin
      o1 = in_tok_i;
      n  = 2'd1;
    end
  end

  // Output register with a spill register for the second token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ext_valid_q <= 1'b0;
      out_tok_q   <= '0;
      ext_tok_q   <= '0;
    end else begin
      if (in_fire) begin
        pend_q <= pend_d;
      end
      if (slot_free) begin
        if (ext_valid_q) begin
          out_valid_q <= 1'b1;
          out_tok_q   <= ext_tok_q;
          ext_valid_q <= 1'b0;
        end else if (in_fire) begin
          out_valid_q <= (n != 2'd0);
          out_tok_q   <= o1;
          ext_valid_q <= (n == 2'd2);
          ext_tok_q   <= o2;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/backslash_escape_decoder_core.sv
// Top level of the backslash escape decoder: hex front, token queue and
// five replacement stages in series. Depends on bsed_pkg, the channel
// interfaces, bsed_hex_front, bsed_fifo and bsed_repl_stage.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+----------------------------------
//   in_i     | sink      | valid / ready  | in_byte[7:0], is_last
//   out_o    | source    | valid / ready  | out_byte[7:0], has_byte, end_of_message
//   cfg      | write     | cfg_we_i       | cfg_wdata_i = escape_enable
//
// An ordinary byte is registered once in the front, once in the queue and once in
// each of the five stages, so one item per cycle goes through unless stalled,
// and its result is offered from the output register of the last stage.
// An item that aborts an escape yields two or three tokens, which the front
// issues one per cycle while the queue takes them; a stage that splits a token
// in two keeps the second in its spill register and accepts nothing meanwhile.
// Reset clears all decode state and sets escape_enable. Each side stalls on its
// own through the queue and the stage registers; a stalled output holds its item.
module backslash_escape_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  bsed_in_if.sink   in_i,
  bsed_out_if.source out_o
);

  localparam int unsigned NS = bsed_pkg::NUM_STAGES;

  logic             enable_q;
  logic             fr_valid, fr_ready;
  bsed_pkg::token_t fr_tok;
  logic             ch_valid [NS+1];
  logic             ch_ready [NS+1];
  bsed_pkg::token_t ch_tok   [NS+1];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Front part: hex escapes and the enable switch.
  bsed_hex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .in_i        (in_i),
    .tok_valid_o (fr_valid),
    .tok_o       (fr_tok),
    .tok_ready_i (fr_ready)
  );

  // Queue between the two parts.
  bsed_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_tok_i   (fr_tok),
    .push_ready_o (fr_ready),
    .pop_valid_o  (ch_valid[0]),
    .pop_tok_o    (ch_tok[0]),
    .pop_ready_i  (ch_ready[0])
  );

  // Back part: the replacement stages in rule order.
  for (genvar g = 0; g < NS; g++) begin : g_stage
    bsed_repl_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rule_i      (bsed_pkg::RULES[g]),
      .in_valid_i  (ch_valid[g]),
      .in_tok_i    (ch_tok[g]),
      .in_ready_o  (ch_ready[g]),
      .out_valid_o (ch_valid[g+1]),
      .out_tok_o   (ch_tok[g+1]),
      .out_ready_i (ch_ready[g+1])
    );
  end

  // Result channel.
  assign out_o.valid          = ch_valid[NS];
  assign out_o.out_byte       = ch_tok[NS].data;
  assign out_o.has_byte       = ch_tok[NS].has_byte;
  assign out_o.end_of_message = ch_tok[NS].last;
  assign ch_ready[NS]         = out_o.ready;

endmodule

### hw/rtl/bsed_checker.sv
// Port-level checks of the backslash escape decoder, bound to the top level.
// Depends on backslash_escape_decoder_core and its output channel.
module bsed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       end_of_message_i
);

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_byte_i) && $stable(has_byte_i) && $stable(end_of_message_i)))
    else $error("result payload changed while stalled");

  // A result without a byte is only ever the bare end of a message, with a zero byte.
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !has_byte_i) |-> (end_of_message_i && (out_byte_i == 8'h00)))
    else $error("bare result that does not end a message");

  // No result is offered while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

endmodule

bind backslash_escape_decoder_core bsed_checker u_bsed_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_i       (out_o.out_byte),
  .has_byte_i       (out_o.has_byte),
  .end_of_message_i (out_o.end_of_message)
);
